### src/triangle_tangent_basis_defines.svh
// ----------------------------------------------------------------------------
// triangle_tangent_basis_defines.svh
// Assertion macros shared by the checker of the tangent basis block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BASIS_DEFINES_SVH
`define TRIANGLE_TANGENT_BASIS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttb assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttb assertion failed");

`endif

### src/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Types, constants and fixed-point helpers of the tangent basis block.
// ----------------------------------------------------------------------------
package ttb_pkg;

    // Fraction bits of the signed fixed-point format.
    localparam int FRAC_BITS = 16;

    // Depth of the triangle queue between front and back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    // One vertex; index 0 of each vector is x (or u).
    typedef struct packed {
        logic [2:0][31:0] nrm;
        logic [1:0][31:0] uv;
        logic [2:0][31:0] pos;
    } vertex_t;

    // One triangle; index 0 is the first vertex.
    typedef vertex_t [2:0] tri_t;

    // One result.
    typedef struct packed {
        logic             last;
        logic             deg;
        logic [2:0][31:0] bitan;
        logic [2:0][31:0] tan;
    } res_t;

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > MAX32)
            r = 32'(MAX32);
        else if (x < MIN32)
            r = 32'(MIN32);
        else
            r = 32'(x);
        return r;
    endfunction

    // Saturating difference of two 32-bit values.
    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        return sat32(d);
    endfunction

endpackage

### src/triangle_tangent_basis.sv
// The sequencer handles one triangle at a time; its pace is set by the bit-serial
// divider (ten divisions per triangle) and the square root unit.
// The front holds two vertices and queues two triangles; input stalls when both are full.
// Reset: rst_n is asynchronous, active low; it clears the vertex slot, the queue
// and the sequencer. Held vertices and datapath registers are not cleared.
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Per-vertex tangent and per-triangle bitangent basis on a vertex stream, Q16.16.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [191:0] m_tdata,
    // last_of_triangle
    output logic         m_tlast,
    // degenerate
    output logic         m_tuser
);
    import ttb_pkg::*;

    vertex_t in_vtx;
    tri_t    q_tri;
    logic    q_valid;
    logic    q_pop;
    res_t    res;

    // Unpack the stream word into one vertex.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            in_vtx.pos[c] = s_tdata[32*c +: 32];
            in_vtx.nrm[c] = s_tdata[160 + 32*c +: 32];
        end
        in_vtx.uv[0] = s_tdata[96 +: 32];
        in_vtx.uv[1] = s_tdata[128 +: 32];
    end

    ttb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_vtx   (in_vtx),
        .q_valid  (q_valid),
        .q_tri    (q_tri),
        .q_pop    (q_pop)
    );

    ttb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_tri     (q_tri),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result item.
    assign m_tdata = {res.bitan[2], res.bitan[1], res.bitan[0],
                      res.tan[2], res.tan[1], res.tan[0]};
    assign m_tlast = res.last;
    assign m_tuser = res.deg;

endmodule

### src/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front
// Groups incoming vertices into triangles and queues whole triangles.
// ----------------------------------------------------------------------------
module ttb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ttb_pkg::vertex_t in_vtx,
    output logic           q_valid,
    output ttb_pkg::tri_t  q_tri,
    input  logic           q_pop
);
    import ttb_pkg::*;

    logic [1:0]        slot_reg;
    vertex_t           held0_reg;
    vertex_t           held1_reg;
    tri_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              accept;
    logic              push;
    logic              pop;

    // The first two vertices always fit; the third needs a free queue entry.
    assign in_ready = (slot_reg != 2'd2) || (cnt_reg != QCNT_W'(QDEPTH));
    assign accept   = in_valid && in_ready;
    assign push     = accept && (slot_reg == 2'd2);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_tri    = mem[rd_ptr_reg];

    // Vertex slot and queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
                slot_reg <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Held vertices and queue storage.
    always_ff @(posedge clk)
    begin
        if (accept && slot_reg == 2'd0)
            held0_reg <= in_vtx;
        if (accept && slot_reg == 2'd1)
            held1_reg <= in_vtx;
        if (push)
            mem[wr_ptr_reg] <= {in_vtx, held1_reg, held0_reg};
    end

endmodule

### src/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div
// Bit-serial unsigned divider, 64-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module ttb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic        ge;

    // One quotient bit per cycle.
    assign rem_sh   = {rem_reg, q_reg[63]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend and quotient share one shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

endmodule

### src/ttb_sqrt.sv
// ----------------------------------------------------------------------------
// ttb_sqrt
// Bit-pair integer square root of a 64-bit value, one step per cycle.
// ----------------------------------------------------------------------------
module ttb_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        ge;

    assign trial = res_reg + bit_reg;
    assign ge    = v_reg >= trial;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, partial root and trial bit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

### src/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back
// Sequencer that computes the tangent basis of one queued triangle with one
// shared multiplier, the divider and the square root unit.
// ----------------------------------------------------------------------------
module ttb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ttb_pkg::tri_t  q_tri,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output ttb_pkg::res_t  out_res
);
    import ttb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DET, S_RECIP, S_TB, S_DOT, S_ORTH,
        S_SQRT, S_NORM, S_CROSS, S_HAND, S_EMIT
    } state_t;

    state_t             state_reg;
    logic [2:0]         j_reg;
    logic [1:0]         i_reg;
    logic [1:0]         k_reg;
    logic               ph_reg;
    logic               deg_reg;
    logic               zall_reg;
    logic               out_valid_reg;
    res_t               out_reg;

    logic signed [31:0] nrm_reg [3][3];
    logic signed [31:0] dp1_reg [3];
    logic signed [31:0] dp2_reg [3];
    logic signed [31:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [31:0] det_reg, r_reg, tmp_reg, d_reg;
    logic signed [31:0] tv_reg [3];
    logic signed [31:0] bv_reg [3];
    logic signed [31:0] o_reg [3];
    logic signed [31:0] tt_reg [3];
    logic signed [31:0] c_reg [3];
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        len2_reg;
    logic [31:0]        len_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_c;
    logic signed [63:0] prod_asr;
    logic signed [63:0] acc_sub;
    logic signed [31:0] diff_sat;
    logic signed [63:0] acc_add;
    logic [1:0]         jh;
    logic               emit_ok;

    logic               div_start;
    logic [63:0]        div_dvd;
    logic [31:0]        div_den;
    logic               div_done;
    logic [63:0]        div_q;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic [31:0]        det_mag;
    logic [31:0]        o_mag;
    logic signed [63:0] q_signed;

    // Shared units.
    ttb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    ttb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (len2_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign jh        = j_reg[2:1];
    assign prod_asr  = prod_reg >>> FRAC_BITS;
    assign acc_sub   = acc_reg - prod_reg;
    assign diff_sat  = sat32(acc_sub >>> FRAC_BITS);
    assign acc_add   = acc_reg + prod_asr;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Divider and root start requests.
    assign det_mag   = det_reg[31] ? 32'(-det_reg) : 32'(det_reg);
    assign o_mag     = o_reg[j_reg[1:0]][31] ? 32'(-o_reg[j_reg[1:0]])
                                             : 32'(o_reg[j_reg[1:0]]);
    assign div_start = !ph_reg && (state_reg == S_RECIP || state_reg == S_NORM);
    assign div_dvd   = (state_reg == S_RECIP) ? (64'd1 << (2 * FRAC_BITS))
                                              : (64'(o_mag) << FRAC_BITS);
    assign div_den   = (state_reg == S_RECIP) ? det_mag : len_reg;
    assign sq_start  = !ph_reg && (state_reg == S_SQRT);
    assign q_signed  = det_reg[31] ? -$signed(div_q) : $signed(div_q);

    // Operand selection of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DET:
            begin
                mul_a = j_reg[0] ? dv1_reg : du1_reg;
                mul_b = j_reg[0] ? du2_reg : dv2_reg;
            end
            S_TB:
            begin
                case (j_reg)
                    3'd0:    begin mul_a = dp1_reg[i_reg]; mul_b = dv2_reg; end
                    3'd1:    begin mul_a = dp2_reg[i_reg]; mul_b = dv1_reg; end
                    3'd3:    begin mul_a = dp2_reg[i_reg]; mul_b = du1_reg; end
                    3'd4:    begin mul_a = dp1_reg[i_reg]; mul_b = du2_reg; end
                    default: begin mul_a = tmp_reg;        mul_b = r_reg;   end
                endcase
            end
            S_DOT:
            begin
                mul_a = nrm_reg[k_reg][j_reg[1:0]];
                mul_b = tv_reg[j_reg[1:0]];
            end
            S_ORTH:
            begin
                if (j_reg[0])
                begin
                    mul_a = o_reg[jh];
                    mul_b = o_reg[jh];
                end
                else
                begin
                    mul_a = nrm_reg[k_reg][jh];
                    mul_b = d_reg;
                end
            end
            S_CROSS:
            begin
                case (j_reg)
                    3'd0:    begin mul_a = nrm_reg[k_reg][1]; mul_b = tt_reg[2]; end
                    3'd1:    begin mul_a = nrm_reg[k_reg][2]; mul_b = tt_reg[1]; end
                    3'd2:    begin mul_a = nrm_reg[k_reg][2]; mul_b = tt_reg[0]; end
                    3'd3:    begin mul_a = nrm_reg[k_reg][0]; mul_b = tt_reg[2]; end
                    3'd4:    begin mul_a = nrm_reg[k_reg][0]; mul_b = tt_reg[1]; end
                    default: begin mul_a = nrm_reg[k_reg][1]; mul_b = tt_reg[0]; end
                endcase
            end
            S_HAND:
            begin
                mul_a = c_reg[j_reg[1:0]];
                mul_b = bv_reg[j_reg[1:0]];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Sequencer: every multiply takes an issue phase and a use phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            deg_reg       <= 1'b0;
            zall_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_c;
            // The emit state reloads the output register itself.
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                // Take a triangle and form its edge and UV deltas.
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            dp1_reg[c] <= sub_sat(q_tri[1].pos[c], q_tri[0].pos[c]);
                            dp2_reg[c] <= sub_sat(q_tri[2].pos[c], q_tri[0].pos[c]);
                            for (int v = 0; v < 3; v++)
                                nrm_reg[v][c] <= $signed(q_tri[v].nrm[c]);
                        end
                        du1_reg  <= sub_sat(q_tri[1].uv[0], q_tri[0].uv[0]);
                        dv1_reg  <= sub_sat(q_tri[1].uv[1], q_tri[0].uv[1]);
                        du2_reg  <= sub_sat(q_tri[2].uv[0], q_tri[0].uv[0]);
                        dv2_reg  <= sub_sat(q_tri[2].uv[1], q_tri[0].uv[1]);
                        deg_reg  <= 1'b0;
                        zall_reg <= 1'b0;
                        j_reg    <= '0;
                        ph_reg   <= 1'b0;
                        state_reg <= S_DET;
                    end
                end

                // UV determinant.
                S_DET:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (!j_reg[0])
                        begin
                            acc_reg <= prod_reg;
                            j_reg   <= 3'd1;
                        end
                        else
                        begin
                            det_reg <= diff_sat;
                            k_reg   <= '0;
                            if (diff_sat == 32'sd0)
                            begin
                                deg_reg   <= 1'b1;
                                zall_reg  <= 1'b1;
                                state_reg <= S_EMIT;
                            end
                            else
                                state_reg <= S_RECIP;
                        end
                    end
                end

                // Reciprocal of the determinant.
                S_RECIP:
                begin
                    if (ph_reg && div_done)
                    begin
                        r_reg     <= sat32(q_signed);
                        ph_reg    <= 1'b0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_TB;
                    end
                    else
                        ph_reg <= 1'b1;
                end

                // Triangle tangent and bitangent, one component at a time.
                S_TB:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        case (j_reg)
                            3'd0, 3'd3: acc_reg <= prod_reg;
                            3'd1, 3'd4: tmp_reg <= diff_sat;
                            3'd2:       tv_reg[i_reg] <= sat32(prod_asr);
                            default:    bv_reg[i_reg] <= sat32(prod_asr);
                        endcase
                        if (j_reg == 3'd5)
                        begin
                            j_reg <= '0;
                            if (i_reg == 2'd2)
                            begin
                                k_reg     <= '0;
                                state_reg <= S_DOT;
                            end
                            else
                                i_reg <= i_reg + 2'd1;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                end

                // Dot product of this vertex's normal with the tangent.
                S_DOT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (j_reg == 3'd0)
                            acc_reg <= prod_asr;
                        else
                            acc_reg <= acc_add;
                        if (j_reg == 3'd2)
                        begin
                            d_reg     <= sat32(acc_add);
                            j_reg     <= '0;
                            state_reg <= S_ORTH;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                end

                // Gram-Schmidt step and squared length.
                S_ORTH:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (!j_reg[0])
                            o_reg[jh] <= sub_sat(tv_reg[jh], sat32(prod_asr));
                        else if (j_reg == 3'd1)
                            len2_reg <= 64'(prod_reg);
                        else
                            len2_reg <= len2_reg + 64'(prod_reg);
                        if (j_reg == 3'd5)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_SQRT;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                end

                // Length of the orthogonalized tangent.
                S_SQRT:
                begin
                    if (ph_reg && sq_done)
                    begin
                        ph_reg  <= 1'b0;
                        len_reg <= sq_root;
                        j_reg   <= '0;
                        if (sq_root == 32'd0)
                        begin
                            deg_reg   <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                            state_reg <= S_NORM;
                    end
                    else
                        ph_reg <= 1'b1;
                end

                // Normalization, one component per division.
                S_NORM:
                begin
                    if (ph_reg && div_done)
                    begin
                        ph_reg <= 1'b0;
                        tt_reg[j_reg[1:0]] <= o_reg[j_reg[1:0]][31] ? -$signed(div_q[31:0])
                                                                    : $signed(div_q[31:0]);
                        if (j_reg == 3'd2)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_CROSS;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                    else
                        ph_reg <= 1'b1;
                end

                // Cross product of the normal with the tangent.
                S_CROSS:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (!j_reg[0])
                            acc_reg <= prod_reg;
                        else
                            c_reg[jh] <= diff_sat;
                        if (j_reg == 3'd5)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_HAND;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                end

                // Handedness test against the bitangent.
                S_HAND:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (j_reg == 3'd0)
                            acc_reg <= prod_asr;
                        else
                            acc_reg <= acc_add;
                        if (j_reg == 3'd2)
                        begin
                            if (acc_add[63])
                                for (int c = 0; c < 3; c++)
                                    tt_reg[c] <= -tt_reg[c];
                            j_reg     <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                end

                // Hand one result to the output register.
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.last  <= (k_reg == 2'd2);
                        out_reg.deg   <= deg_reg;
                        for (int c = 0; c < 3; c++)
                        begin
                            out_reg.tan[c]   <= deg_reg ? 32'd0 : 32'(tt_reg[c]);
                            out_reg.bitan[c] <= deg_reg ? 32'd0 : 32'(bv_reg[c]);
                        end
                        ph_reg <= 1'b0;
                        j_reg  <= '0;
                        if (k_reg == 2'd2)
                            state_reg <= S_IDLE;
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                            if (!zall_reg)
                            begin
                                deg_reg   <= 1'b0;
                                state_reg <= S_DOT;
                            end
                        end
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### src/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks of the tangent basis block, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_tangent_basis_defines.svh"

module ttb_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [255:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         m_tlast,
    input logic         m_tuser
);
    import ttb_pkg::*;

    // A stalled result stays offered, with its data and degenerate flag unchanged.
    `TTB_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `TTB_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // A flagged result carries zero vectors.
    `TTB_ASSERT_IMP(a_deg_zero, m_tvalid && m_tuser, m_tdata == '0)

    // The x component of a normalized tangent never exceeds one in magnitude.
    `TTB_ASSERT_IMP(a_tan_unit, m_tvalid && !m_tuser, $signed(m_tdata[31:0]) <= ONE_Q && $signed(m_tdata[31:0]) >= -ONE_Q)

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (.*);
